// ===== hw/rtl/spqu_pkg.sv =====
// Shared types and codes for the stable priority request queue.
package spqu_pkg;

  localparam int unsigned DEPTH_DEF    = 16;
  localparam int unsigned TAG_BITS_DEF = 16;
  localparam int unsigned KIND_W       = 4;
  localparam int unsigned PRIO_W       = 8;
  localparam int unsigned ERR_W        = 8;
  localparam int unsigned STATUS_W     = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQUEUE = 4'd0,
    KIND_INSERT  = 4'd1,
    KIND_DEQUEUE = 4'd2,
    KIND_REQUEUE = 4'd3,
    KIND_REMOVE  = 4'd4,
    KIND_MOVE    = 4'd5,
    KIND_UPDATE  = 4'd6,
    KIND_READ    = 4'd7,
    KIND_CLEAR   = 4'd8
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  // Per-cycle command broadcast to every cell.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUT,
    CELL_ENQ,
    CELL_TAKE,
    CELL_MOVE_UP,
    CELL_MOVE_DN,
    CELL_WRITE
  } cell_op_t;

endpackage

// ===== hw/rtl/spqu_cell.sv =====
// One queue slot: holds an entry and picks its next value from itself, a neighbour or the new entry.
module spqu_cell
  import spqu_pkg::*;
#(
  parameter int unsigned TAG_BITS = TAG_BITS_DEF,
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned CNT_W    = 5,
  parameter int unsigned ID       = 0
) (
  input  logic                     clk,
  input  cell_op_t                 op,
  input  logic [IDX_W-1:0]         idx_a,
  input  logic [IDX_W-1:0]         idx_b,
  input  logic [CNT_W-1:0]         fill,
  input  logic [TAG_BITS-1:0]      new_tag,
  input  logic signed [PRIO_W-1:0] new_prio,
  input  logic [ERR_W-1:0]         new_err,
  input  logic [TAG_BITS-1:0]      left_tag,
  input  logic signed [PRIO_W-1:0] left_prio,
  input  logic [ERR_W-1:0]         left_err,
  input  logic [TAG_BITS-1:0]      right_tag,
  input  logic signed [PRIO_W-1:0] right_prio,
  input  logic [ERR_W-1:0]         right_err,
  input  logic                     seen_in,
  output logic                     seen_out,
  output logic [TAG_BITS-1:0]      tag,
  output logic signed [PRIO_W-1:0] prio,
  output logic [ERR_W-1:0]         err
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(ID);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(ID);

  logic take_new, take_left, take_right;

  // Enqueue slot search: first occupied slot of lower priority, else the first free one.
  assign seen_out = seen_in || (MY_CNT == fill) || ((MY_CNT < fill) && (new_prio > prio));

  always_comb begin
    take_new   = 1'b0;
    take_left  = 1'b0;
    take_right = 1'b0;
    unique case (op)
      CELL_PUT: begin
        take_new  = (MY_IDX == idx_a);
        take_left = (MY_IDX > idx_a);
      end
      CELL_ENQ: begin
        take_new  = seen_out && !seen_in;
        take_left = seen_in;
      end
      CELL_TAKE: begin
        take_right = (MY_IDX >= idx_a);
      end
      CELL_MOVE_UP: begin
        take_new   = (MY_IDX == idx_b);
        take_right = (MY_IDX >= idx_a) && (MY_IDX < idx_b);
      end
      CELL_MOVE_DN: begin
        take_new  = (MY_IDX == idx_b);
        take_left = (MY_IDX > idx_b) && (MY_IDX <= idx_a);
      end
      CELL_WRITE: begin
        take_new = (MY_IDX == idx_a);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (take_new) begin
      tag  <= new_tag;
      prio <= new_prio;
      err  <= new_err;
    end else if (take_left) begin
      tag  <= left_tag;
      prio <= left_prio;
      err  <= left_err;
    end else if (take_right) begin
      tag  <= right_tag;
      prio <= right_prio;
      err  <= right_err;
    end
  end

endmodule

// ===== hw/rtl/stable_priority_request_queue_unit.sv =====
// Stable priority request queue: the result beat comes in the cycle after acceptance.
// Throughput one op per cycle when not stalled; each is done in the accept cycle by
// the row of cells, each of which reloads from itself, a neighbour or the new entry.
// The result register sits between the two sides; input stalls only while it is held.
// Reset (rst, synchronous) empties the queue and drops any waiting result beat.
module stable_priority_request_queue_unit
  import spqu_pkg::*;
#(
  parameter int unsigned DEPTH    = DEPTH_DEF,
  parameter int unsigned TAG_BITS = TAG_BITS_DEF,
  parameter int unsigned IDX_W    = $clog2(DEPTH),
  parameter int unsigned CNT_W    = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [KIND_W-1:0]        kind,
  input  logic [TAG_BITS-1:0]      tag,
  input  logic signed [PRIO_W-1:0] priority_req,
  input  logic [ERR_W-1:0]         error_count,
  input  logic [CNT_W-1:0]         position,
  input  logic [IDX_W-1:0]         dest_position,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STATUS_W-1:0]      status,
  output logic [TAG_BITS-1:0]      out_tag,
  output logic signed [PRIO_W-1:0] out_priority,
  output logic [ERR_W-1:0]         out_error_count,
  output logic [CNT_W-1:0]         occupancy
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // Entry count and accept handshake
  logic [CNT_W-1:0] fill, fill_next;
  logic             accept;

  // Per-beat decode
  cell_op_t                 op;
  logic [IDX_W-1:0]         idx_a, idx_b;
  logic [TAG_BITS-1:0]      new_tag;
  logic signed [PRIO_W-1:0] new_prio;
  logic [ERR_W-1:0]         new_err;
  status_t                  st;
  logic                     show;
  logic [IDX_W-1:0]         rd_idx;
  logic                     is_full, is_empty, pos_ok, dst_ok;
  logic [ERR_W-1:0]         err_inc;

  // Cell row
  logic [TAG_BITS-1:0]      cell_tag  [DEPTH];
  logic signed [PRIO_W-1:0] cell_prio [DEPTH];
  logic [ERR_W-1:0]         cell_err  [DEPTH];
  logic [DEPTH:0]           seen;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign is_full  = (fill == FULL_CNT);
  assign is_empty = (fill == '0);
  assign pos_ok   = (position < fill);
  assign dst_ok   = (CNT_W'(dest_position) < fill);
  assign err_inc  = (error_count == '1) ? error_count : error_count + ERR_W'(1);

  // Dequeue reads the head; read and move use the source index.
  assign rd_idx = (kind_t'(kind) == KIND_DEQUEUE) ? '0 : position[IDX_W-1:0];

  always_comb begin
    op        = CELL_HOLD;
    idx_a     = position[IDX_W-1:0];
    idx_b     = dest_position;
    new_tag   = tag;
    new_prio  = priority_req;
    new_err   = error_count;
    st        = ST_OK;
    show      = 1'b0;
    fill_next = fill;
    unique case (kind_t'(kind))
      KIND_ENQUEUE, KIND_INSERT, KIND_REQUEUE: begin
        if (is_full) begin
          st = ST_FULL;
        end else begin
          fill_next = fill + CNT_W'(1);
          if (kind_t'(kind) == KIND_ENQUEUE) begin
            op = CELL_ENQ;
          end else if (kind_t'(kind) == KIND_INSERT) begin
            op    = CELL_PUT;
            // past the end clamps to an append
            idx_a = (position > fill) ? fill[IDX_W-1:0] : position[IDX_W-1:0];
          end else begin
            op      = CELL_PUT;
            idx_a   = '0;
            new_err = err_inc;
          end
        end
      end
      KIND_DEQUEUE, KIND_REMOVE, KIND_MOVE, KIND_UPDATE, KIND_READ: begin
        if (is_empty) begin
          st = ST_EMPTY;
        end else if (kind_t'(kind) == KIND_DEQUEUE) begin
          op        = CELL_TAKE;
          idx_a     = '0;
          show      = 1'b1;
          fill_next = fill - CNT_W'(1);
        end else if (!pos_ok) begin
          st = ST_BAD;
        end else if (kind_t'(kind) == KIND_REMOVE) begin
          op        = CELL_TAKE;
          fill_next = fill - CNT_W'(1);
        end else if (kind_t'(kind) == KIND_MOVE) begin
          if (!dst_ok || (position[IDX_W-1:0] == dest_position)) begin
            st = ST_BAD;
          end else begin
            op       = (position[IDX_W-1:0] < dest_position) ? CELL_MOVE_UP : CELL_MOVE_DN;
            new_tag  = cell_tag[rd_idx];
            new_prio = cell_prio[rd_idx];
            new_err  = cell_err[rd_idx];
          end
        end else if (kind_t'(kind) == KIND_UPDATE) begin
          op = CELL_WRITE;
        end else begin
          show = 1'b1;
        end
      end
      KIND_CLEAR: begin
        fill_next = '0;
      end
      default: begin
        st = ST_BAD;
      end
    endcase
    if (!accept) begin
      op = CELL_HOLD;
    end
  end

  // Cell row: inner cells see both neighbours; the enqueue search ripples along seen.
  assign seen[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [TAG_BITS-1:0]      l_tag, r_tag;
    logic signed [PRIO_W-1:0] l_prio, r_prio;
    logic [ERR_W-1:0]         l_err, r_err;

    if (i == 0) begin : g_first
      assign l_tag  = cell_tag[i];
      assign l_prio = cell_prio[i];
      assign l_err  = cell_err[i];
    end else begin : g_mid_l
      assign l_tag  = cell_tag[i-1];
      assign l_prio = cell_prio[i-1];
      assign l_err  = cell_err[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_tag  = cell_tag[i];
      assign r_prio = cell_prio[i];
      assign r_err  = cell_err[i];
    end else begin : g_mid_r
      assign r_tag  = cell_tag[i+1];
      assign r_prio = cell_prio[i+1];
      assign r_err  = cell_err[i+1];
    end

    spqu_cell #(
      .TAG_BITS (TAG_BITS),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W),
      .ID       (i)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .idx_a      (idx_a),
      .idx_b      (idx_b),
      .fill       (fill),
      .new_tag    (new_tag),
      .new_prio   (new_prio),
      .new_err    (new_err),
      .left_tag   (l_tag),
      .left_prio  (l_prio),
      .left_err   (l_err),
      .right_tag  (r_tag),
      .right_prio (r_prio),
      .right_err  (r_err),
      .seen_in    (seen[i]),
      .seen_out   (seen[i+1]),
      .tag        (cell_tag[i]),
      .prio       (cell_prio[i]),
      .err        (cell_err[i])
    );
  end

  // Fill count and output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else if (accept) begin
      fill      <= fill_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status          <= st;
      occupancy       <= fill_next;
      out_tag         <= show ? cell_tag[rd_idx]  : '0;
      out_priority    <= show ? cell_prio[rd_idx] : '0;
      out_error_count <= show ? cell_err[rd_idx]  : '0;
    end
  end

endmodule
